/* rtl/blrd_pkg.sv */
// Package for the line and rectangle draw engine.
// Holds the default coordinate width and the command and shape codes.
// No dependencies.
package blrd_pkg;

  // Default width of the signed input coordinates
  localparam int unsigned COORD_BITS_DEF = 12;

  // Command kinds carried in the kind field
  localparam logic KIND_START = 1'b0;
  localparam logic KIND_TICK  = 1'b1;

  // Shape codes; code 3 is unused and leaves the engine idle
  typedef enum logic [1:0] {
    SHAPE_LINE    = 2'd0,
    SHAPE_OUTLINE = 2'd1,
    SHAPE_FILLED  = 2'd2
  } shape_e;

endpackage : blrd_pkg

/* rtl/blrd_if.sv */
// Valid/ready channel interfaces of the draw engine: command in, pixel out.
// Depends on blrd_pkg for the default coordinate width.

// Command channel: start or tick transactions
interface blrd_cmd_if
  import blrd_pkg::*;
#(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic                         kind;
  logic [1:0]                   shape;
  logic signed [COORD_BITS-1:0] coord_a_x;
  logic signed [COORD_BITS-1:0] coord_a_y;
  logic signed [COORD_BITS-1:0] coord_b_x;
  logic signed [COORD_BITS-1:0] coord_b_y;
  logic [7:0]                   red;
  logic [7:0]                   green;
  logic [7:0]                   blue;

  modport source (
    output valid, kind, shape, coord_a_x, coord_a_y, coord_b_x, coord_b_y,
           red, green, blue,
    input  ready
  );
  modport sink (
    input  valid, kind, shape, coord_a_x, coord_a_y, coord_b_x, coord_b_y,
           red, green, blue,
    output ready
  );
endinterface : blrd_cmd_if

// Pixel channel: one plotted pixel per transaction
interface blrd_pix_if
  import blrd_pkg::*;
#(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
);
  logic                       valid;
  logic                       ready;
  logic signed [COORD_BITS:0] pixel_x;
  logic signed [COORD_BITS:0] pixel_y;
  logic [7:0]                 pixel_red;
  logic [7:0]                 pixel_green;
  logic [7:0]                 pixel_blue;
  logic                       last_of_command;

  modport source (
    output valid, pixel_x, pixel_y, pixel_red, pixel_green, pixel_blue,
           last_of_command,
    input  ready
  );
  modport sink (
    input  valid, pixel_x, pixel_y, pixel_red, pixel_green, pixel_blue,
           last_of_command,
    output ready
  );
endinterface : blrd_pix_if

/* rtl/bresenham_line_rect_drawer_top.sv */
// Line and rectangle draw engine: Bresenham lines, rectangle outlines and
// filled rectangles. One start or tick transaction is accepted per clock while
// the output register is free or draining. An accepted tick on an active
// command loads its pixel into the output register at the accepting edge, so
// the pixel is offered from the next cycle and pixels stream at one per cycle
// while the pixel side keeps ready high, as the stepping logic between the
// command state and the output register is combinational. A waiting pixel
// blocks the command channel only while the pixel side holds ready low; in
// the cycle that the pixel is taken the next transaction goes straight in. A
// start yields no pixel; a rectangle moves to its next side or row with no gap.
// Depends on blrd_pkg and the channel interfaces in blrd_if.sv.
module bresenham_line_rect_drawer_top
  import blrd_pkg::*;
#(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  blrd_cmd_if.sink   cmd_i,
  blrd_pix_if.source pix_o
);

  localparam int unsigned CB = COORD_BITS;
  localparam int unsigned EW = CB + 3;

  // Outline sides, in drawing order
  localparam logic [CB-1:0] SEG_TOP    = CB'(0);
  localparam logic [CB-1:0] SEG_BOTTOM = CB'(1);
  localparam logic [CB-1:0] SEG_LEFT   = CB'(2);
  localparam logic [CB-1:0] SEG_RIGHT  = CB'(3);

  // Command state
  logic                 busy_q, busy_d;
  logic [1:0]           shape_q, shape_d;
  logic [CB-1:0]        seg_q, seg_d;
  logic signed [CB:0]   cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  logic signed [CB:0]   tgt_x_q, tgt_x_d, tgt_y_q, tgt_y_d;
  logic [CB-1:0]        dist_x_q, dist_x_d, dist_y_q, dist_y_d;
  logic                 neg_x_q, neg_x_d, neg_y_q, neg_y_d;
  logic signed [EW-1:0] err_q, err_d;
  logic signed [CB:0]   org_x_q, org_x_d, org_y_q, org_y_d;
  logic signed [CB:0]   right_x_q, right_x_d, bot_y_q, bot_y_d;
  logic [CB-1:0]        wm1_q, wm1_d, hm1_q, hm1_d;
  logic [7:0]           red_q, red_d, green_q, green_d, blue_q, blue_d;

  // Output register
  logic                 out_valid_q;
  logic signed [CB:0]   pix_x_q, pix_y_q;
  logic [7:0]           pix_r_q, pix_g_q, pix_b_q;
  logic                 pix_last_q;

  logic                 acc;
  logic                 emit;
  logic                 last_d;

  // Start decode
  logic signed [CB:0]   ax, ay, bx, by;
  logic signed [CB:0]   dx, dy;
  logic [CB-1:0]        adx, ady;
  logic                 rect_ok;

  // Stepping
  logic                 at_end;
  logic                 more_seg;
  logic [CB-1:0]        seg_n;
  logic signed [EW-1:0] sdx, sdy;
  logic                 step_x, step_y;
  logic [CB-1:0]        bx_m1, by_m1;

  // Accept whenever the output register is free or draining
  assign cmd_i.ready = !out_valid_q || pix_o.ready;
  assign acc         = cmd_i.valid && cmd_i.ready;
  assign emit        = acc && (cmd_i.kind == KIND_TICK) && busy_q;

  // Sign-extend the operands and form the line deltas
  assign ax    = {cmd_i.coord_a_x[CB-1], cmd_i.coord_a_x};
  assign ay    = {cmd_i.coord_a_y[CB-1], cmd_i.coord_a_y};
  assign bx    = {cmd_i.coord_b_x[CB-1], cmd_i.coord_b_x};
  assign by    = {cmd_i.coord_b_y[CB-1], cmd_i.coord_b_y};
  assign dx    = bx - ax;
  assign dy    = by - ay;
  assign adx   = dx[CB] ? CB'(-dx) : dx[CB-1:0];
  assign ady   = dy[CB] ? CB'(-dy) : dy[CB-1:0];
  assign bx_m1 = cmd_i.coord_b_x - CB'(1);
  assign by_m1 = cmd_i.coord_b_y - CB'(1);
  assign rect_ok = !cmd_i.coord_b_x[CB-1] && (cmd_i.coord_b_x != '0) &&
                   !cmd_i.coord_b_y[CB-1] && (cmd_i.coord_b_y != '0);

  // End of segment and whether another side or row follows
  assign at_end   = (cur_x_q == tgt_x_q) && (cur_y_q == tgt_y_q);
  assign more_seg = ((shape_q == SHAPE_OUTLINE) && (seg_q != SEG_RIGHT)) ||
                    ((shape_q == SHAPE_FILLED) && (seg_q < hm1_q));
  assign seg_n    = seg_q + CB'(1);

  // Bresenham decisions on the current error
  assign sdx    = $signed({3'b000, dist_x_q});
  assign sdy    = $signed({3'b000, dist_y_q});
  assign step_x = err_q > -sdx;
  assign step_y = err_q < sdy;

  // Next command state
  always_comb begin
    busy_d    = busy_q;
    shape_d   = shape_q;
    seg_d     = seg_q;
    cur_x_d   = cur_x_q;
    cur_y_d   = cur_y_q;
    tgt_x_d   = tgt_x_q;
    tgt_y_d   = tgt_y_q;
    dist_x_d  = dist_x_q;
    dist_y_d  = dist_y_q;
    neg_x_d   = neg_x_q;
    neg_y_d   = neg_y_q;
    err_d     = err_q;
    org_x_d   = org_x_q;
    org_y_d   = org_y_q;
    right_x_d = right_x_q;
    bot_y_d   = bot_y_q;
    wm1_d     = wm1_q;
    hm1_d     = hm1_q;
    red_d     = red_q;
    green_d   = green_q;
    blue_d    = blue_q;
    last_d    = 1'b0;

    if (acc && (cmd_i.kind == KIND_START)) begin
      // Load a new command, replacing any in progress
      shape_d = cmd_i.shape;
      seg_d   = SEG_TOP;
      red_d   = cmd_i.red;
      green_d = cmd_i.green;
      blue_d  = cmd_i.blue;
      busy_d  = 1'b0;
      if (cmd_i.shape == SHAPE_LINE) begin
        cur_x_d  = ax;
        cur_y_d  = ay;
        tgt_x_d  = bx;
        tgt_y_d  = by;
        dist_x_d = adx;
        dist_y_d = ady;
        neg_x_d  = dx[CB];
        neg_y_d  = dy[CB];
        err_d    = (adx > ady) ? $signed(EW'(adx >> 1)) : -$signed(EW'(ady >> 1));
        busy_d   = 1'b1;
      end else if ((cmd_i.shape == SHAPE_OUTLINE) || (cmd_i.shape == SHAPE_FILLED)) begin
        org_x_d   = ax;
        org_y_d   = ay;
        right_x_d = ax + bx - (CB+1)'(1);
        bot_y_d   = ay + by - (CB+1)'(1);
        wm1_d     = bx_m1;
        hm1_d     = by_m1;
        // Top side, also the first filled row
        cur_x_d   = ax;
        cur_y_d   = ay;
        tgt_x_d   = ax + bx - (CB+1)'(1);
        tgt_y_d   = ay;
        dist_x_d  = bx_m1;
        dist_y_d  = '0;
        neg_x_d   = 1'b0;
        neg_y_d   = 1'b0;
        err_d     = $signed(EW'(bx_m1 >> 1));
        busy_d    = rect_ok;
      end
    end else if (emit) begin
      if (at_end) begin
        if (more_seg) begin
          // Advance to the next side or row
          seg_d   = seg_n;
          neg_x_d = 1'b0;
          neg_y_d = 1'b0;
          if ((shape_q == SHAPE_FILLED) || (seg_n == SEG_BOTTOM)) begin
            cur_x_d  = org_x_q;
            tgt_x_d  = right_x_q;
            cur_y_d  = (shape_q == SHAPE_FILLED) ? cur_y_q + (CB+1)'(1) : bot_y_q;
            tgt_y_d  = (shape_q == SHAPE_FILLED) ? cur_y_q + (CB+1)'(1) : bot_y_q;
            dist_x_d = wm1_q;
            dist_y_d = '0;
            err_d    = $signed(EW'(wm1_q >> 1));
          end else begin
            cur_x_d  = (seg_n == SEG_LEFT) ? org_x_q : right_x_q;
            tgt_x_d  = (seg_n == SEG_LEFT) ? org_x_q : right_x_q;
            cur_y_d  = org_y_q;
            tgt_y_d  = bot_y_q;
            dist_x_d = '0;
            dist_y_d = hm1_q;
            err_d    = -$signed(EW'(hm1_q >> 1));
          end
        end else begin
          last_d = 1'b1;
          busy_d = 1'b0;
        end
      end else begin
        // Step along the line
        err_d = err_q - (step_x ? sdy : EW'(0)) + (step_y ? sdx : EW'(0));
        if (step_x) begin
          cur_x_d = neg_x_q ? cur_x_q - (CB+1)'(1) : cur_x_q + (CB+1)'(1);
        end
        if (step_y) begin
          cur_y_d = neg_y_q ? cur_y_q - (CB+1)'(1) : cur_y_q + (CB+1)'(1);
        end
      end
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      shape_q     <= SHAPE_LINE;
      seg_q       <= SEG_TOP;
      out_valid_q <= 1'b0;
    end else begin
      busy_q  <= busy_d;
      shape_q <= shape_d;
      seg_q   <= seg_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (pix_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    cur_x_q   <= cur_x_d;
    cur_y_q   <= cur_y_d;
    tgt_x_q   <= tgt_x_d;
    tgt_y_q   <= tgt_y_d;
    dist_x_q  <= dist_x_d;
    dist_y_q  <= dist_y_d;
    neg_x_q   <= neg_x_d;
    neg_y_q   <= neg_y_d;
    err_q     <= err_d;
    org_x_q   <= org_x_d;
    org_y_q   <= org_y_d;
    right_x_q <= right_x_d;
    bot_y_q   <= bot_y_d;
    wm1_q     <= wm1_d;
    hm1_q     <= hm1_d;
    red_q     <= red_d;
    green_q   <= green_d;
    blue_q    <= blue_d;
    // Capture the pixel of an accepted tick
    if (emit) begin
      pix_x_q    <= cur_x_q;
      pix_y_q    <= cur_y_q;
      pix_r_q    <= red_q;
      pix_g_q    <= green_q;
      pix_b_q    <= blue_q;
      pix_last_q <= last_d;
    end
  end

  assign pix_o.valid           = out_valid_q;
  assign pix_o.pixel_x         = pix_x_q;
  assign pix_o.pixel_y         = pix_y_q;
  assign pix_o.pixel_red       = pix_r_q;
  assign pix_o.pixel_green     = pix_g_q;
  assign pix_o.pixel_blue      = pix_b_q;
  assign pix_o.last_of_command = pix_last_q;

  // A tick on an idle engine leaves no pixel behind
  a_idle_tick_silent: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (acc && (cmd_i.kind == KIND_TICK) && !busy_q) |=> !out_valid_q
  ) else $error("pixel produced by a tick while idle");

  // The final pixel of a command drops busy
  a_last_ends_cmd: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (emit && last_d) |=> (!busy_q && out_valid_q && pix_o.last_of_command)
  ) else $error("engine still busy after the last pixel");

  // An outline never walks past its fourth side
  a_outline_sides: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (busy_q && (shape_q == SHAPE_OUTLINE)) |-> (seg_q <= SEG_RIGHT)
  ) else $error("outline side index out of range");

endmodule : bresenham_line_rect_drawer_top

/* tb/sv/bresenham_line_rect_drawer_top_tb.sv */
// Self-checking testbench for the line and rectangle draw engine.
// Streams start and tick transactions, predicts every pixel and checks the pixel channel.
// Depends on blrd_pkg, the channel interfaces in blrd_if.sv and the engine top level.
module bresenham_line_rect_drawer_top_tb;
  import blrd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] SHAPE_UNUSED = 2'd3;
  localparam int         MAX_CYCLES   = 400000;
  localparam int         DRAIN_CYCLES = 20;
  localparam int         HOLD_CYCLES  = 80;
  localparam int         TOTAL_ITEMS  = 850;

  typedef struct {
    logic              kind;
    logic [1:0]        shape;
    logic signed [11:0] ax, ay, bx, by;
    logic [7:0]        r, g, b;
    int                phase;
    bit                drain_first;
    bit                hold_rx;
  } draw_cmd_t;

  typedef struct {
    logic signed [12:0] x, y;
    logic [7:0]         r, g, b;
    logic               last;
  } pixel_t;

  logic clk_i;
  logic rst_ni;

  blrd_cmd_if cmd_bus ();
  blrd_pix_if pix_bus ();

  bresenham_line_rect_drawer_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_bus),
    .pix_o  (pix_bus)
  );

  draw_cmd_t cmd_pending[$];
  pixel_t    pixel_expect[$];
  int        fail_count;
  int        cycle_count;
  int        gen_phase;
  int        traffic_phase;
  logic      rx_hold_req;
  int        hold_left;

  // Engine state as seen by the pixel predictor
  int         cur_x, cur_y, tgt_x, tgt_y, dist_x, dist_y, err;
  bit         neg_x, neg_y, busy;
  logic [1:0] mode;
  int         seg, org_x, org_y, rect_w, rect_h;
  logic [7:0] col_r, col_g, col_b;

  // Clock: 4 ns period
  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  // Set up one Bresenham line
  task automatic load_line(input int x0, input int y0, input int x1, input int y1);
    int dx, dy;
    dx     = x1 - x0;
    dy     = y1 - y0;
    dist_x = (dx < 0) ? -dx : dx;
    dist_y = (dy < 0) ? -dy : dy;
    neg_x  = dx < 0;
    neg_y  = dy < 0;
    err    = ((dist_x > dist_y) ? dist_x : -dist_y) / 2;
    cur_x  = x0;
    cur_y  = y0;
    tgt_x  = x1;
    tgt_y  = y1;
  endtask

  // Set up the line of the current side or row of the rectangle
  task automatic load_segment();
    int xr, yb;
    xr = org_x + rect_w - 1;
    yb = org_y + rect_h - 1;
    if (mode == SHAPE_FILLED) begin
      load_line(org_x, org_y + seg, xr, org_y + seg);
    end else begin
      case (seg)
        0:       load_line(org_x, org_y, xr, org_y);
        1:       load_line(org_x, yb, xr, yb);
        2:       load_line(org_x, org_y, org_x, yb);
        default: load_line(xr, org_y, xr, yb);
      endcase
    end
  endtask

  // Advance the predicted engine by one accepted transaction
  task automatic advance_engine(input draw_cmd_t c);
    pixel_t p;
    int     e2, count;
    if (c.kind == KIND_START) begin
      col_r = c.r;
      col_g = c.g;
      col_b = c.b;
      mode  = c.shape;
      seg   = 0;
      busy  = 1'b0;
      if (c.shape == SHAPE_LINE) begin
        load_line(int'(c.ax), int'(c.ay), int'(c.bx), int'(c.by));
        busy = 1'b1;
      end else if (c.shape == SHAPE_OUTLINE || c.shape == SHAPE_FILLED) begin
        org_x  = int'(c.ax);
        org_y  = int'(c.ay);
        rect_w = int'(c.bx);
        rect_h = int'(c.by);
        if (rect_w >= 1 && rect_h >= 1) begin
          load_segment();
          busy = 1'b1;
        end
      end
    end else if (busy) begin
      p.x    = cur_x[12:0];
      p.y    = cur_y[12:0];
      p.r    = col_r;
      p.g    = col_g;
      p.b    = col_b;
      p.last = 1'b0;
      if (cur_x == tgt_x && cur_y == tgt_y) begin
        count = (mode == SHAPE_OUTLINE) ? 4 : (mode == SHAPE_FILLED) ? rect_h : 1;
        if (seg + 1 < count) begin
          seg++;
          load_segment();
        end else begin
          p.last = 1'b1;
          busy   = 1'b0;
        end
      end else begin
        e2 = err;
        if (e2 > -dist_x) begin
          err   -= dist_y;
          cur_x += neg_x ? -1 : 1;
        end
        if (e2 < dist_y) begin
          err   += dist_x;
          cur_y += neg_y ? -1 : 1;
        end
      end
      pixel_expect.push_back(p);
    end
  endtask

  task automatic add_cmd(input logic kind, input logic [1:0] shape, input int ax,
                         input int ay, input int bx, input int by, input logic [23:0] col,
                         input bit drain_first = 1'b0, input bit hold_rx = 1'b0);
    draw_cmd_t c;
    c.kind        = kind;
    c.shape       = shape;
    c.ax          = ax[11:0];
    c.ay          = ay[11:0];
    c.bx          = bx[11:0];
    c.by          = by[11:0];
    c.r           = col[23:16];
    c.g           = col[15:8];
    c.b           = col[7:0];
    c.phase       = gen_phase;
    c.drain_first = drain_first;
    c.hold_rx     = hold_rx;
    cmd_pending.push_back(c);
  endtask

  // Ticks carry random junk in the fields that they ignore
  task automatic add_ticks(input int n);
    repeat (n) add_cmd(KIND_TICK, 2'($urandom), $urandom, $urandom, $urandom, $urandom,
                       24'($urandom));
  endtask

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: pixel %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      fail_count++;
    end
  endfunction

  // Command driver: offer the oldest pending transaction, hold it until taken
  always @(posedge clk_i or negedge rst_ni) begin : cmd_driver
    draw_cmd_t f;
    bit        offer, hold_pulse;
    int        idle_pct;
    if (!rst_ni) begin
      cmd_bus.valid <= 1'b0;
      rx_hold_req   <= 1'b0;
      traffic_phase <= 0;
    end else begin
      hold_pulse = 1'b0;
      if (cmd_bus.valid && cmd_bus.ready) begin
        advance_engine(cmd_pending[0]);
        hold_pulse = cmd_pending[0].hold_rx;
        void'(cmd_pending.pop_front());
      end
      rx_hold_req <= hold_pulse;
      if (!(cmd_bus.valid && !cmd_bus.ready)) begin
        offer = 1'b0;
        if (cmd_pending.size() != 0) begin
          f        = cmd_pending[0];
          idle_pct = (f.phase == 0) ? 11 : (f.phase == 1) ? 55 : 0;
          offer    = ($urandom_range(99) >= idle_pct);
          // Pause until every predicted pixel has been taken
          if (f.drain_first && pixel_expect.size() != 0) offer = 1'b0;
        end
        cmd_bus.valid <= offer;
        if (offer) begin
          traffic_phase     <= f.phase;
          cmd_bus.kind      <= f.kind;
          cmd_bus.shape     <= f.shape;
          cmd_bus.coord_a_x <= f.ax;
          cmd_bus.coord_a_y <= f.ay;
          cmd_bus.coord_b_x <= f.bx;
          cmd_bus.coord_b_y <= f.by;
          cmd_bus.red       <= f.r;
          cmd_bus.green     <= f.g;
          cmd_bus.blue      <= f.b;
        end
      end
    end
  end

  // Pixel monitor: check each transaction against the oldest prediction
  always @(posedge clk_i or negedge rst_ni) begin : pix_monitor
    pixel_t want;
    int     idle_pct;
    if (!rst_ni) begin
      pix_bus.ready <= 1'b0;
      hold_left = 0;
    end else begin
      if (pix_bus.valid && pix_bus.ready) begin
        if (pixel_expect.size() == 0) begin
          $display("%0t: unexpected pixel: expected none, actual x=%0d y=%0d", $time,
                   pix_bus.pixel_x, pix_bus.pixel_y);
          fail_count++;
        end else begin
          want = pixel_expect.pop_front();
          check_field("x", int'(want.x), int'(pix_bus.pixel_x));
          check_field("y", int'(want.y), int'(pix_bus.pixel_y));
          check_field("red", want.r, pix_bus.pixel_red);
          check_field("green", want.g, pix_bus.pixel_green);
          check_field("blue", want.b, pix_bus.pixel_blue);
          check_field("last", want.last, pix_bus.last_of_command);
        end
      end
      // Long hold-off on request, random stalls otherwise
      if (rx_hold_req) hold_left = HOLD_CYCLES;
      if (hold_left > 0) begin
        hold_left--;
        pix_bus.ready <= 1'b0;
      end else begin
        idle_pct = (traffic_phase == 0) ? 55 : (traffic_phase == 1) ? 11 : 0;
        pix_bus.ready <= ($urandom_range(99) >= idle_pct);
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > MAX_CYCLES) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Stimulus, reset and end of run
  initial begin
    int  ax, ay, bx, by, dx, dy, count, n, roll, pick;
    bit  pressure_done;
    logic [1:0] shp;
    rst_ni            = 1'b0;
    cmd_bus.valid     = 1'b0;
    cmd_bus.kind      = KIND_TICK;
    cmd_bus.shape     = SHAPE_LINE;
    cmd_bus.coord_a_x = '0;
    cmd_bus.coord_a_y = '0;
    cmd_bus.coord_b_x = '0;
    cmd_bus.coord_b_y = '0;
    cmd_bus.red       = '0;
    cmd_bus.green     = '0;
    cmd_bus.blue      = '0;
    pix_bus.ready     = 1'b0;
    rx_hold_req       = 1'b0;
    fail_count        = 0;
    cycle_count       = 0;
    gen_phase         = 0;
    pressure_done     = 1'b0;
    busy              = 1'b0;

    // Directed: tick while idle, single-pixel line, extreme line replaced mid-way
    add_ticks(1);
    add_cmd(KIND_START, SHAPE_LINE, 0, 0, 0, 0, 24'hFFFFFF);
    add_ticks(2);
    add_cmd(KIND_START, SHAPE_LINE, -2048, 2047, 2047, -2048, 24'h000000);
    add_ticks(2);
    add_cmd(KIND_START, SHAPE_LINE, 3, 1, -2, 3, 24'hA55AC3);
    add_ticks(6);
    // Outline at the widest corner, then a one-pixel outline with repeated corners
    add_cmd(KIND_START, SHAPE_OUTLINE, 2047, -2048, 2047, 2047, 24'h123456);
    add_ticks(1);
    add_cmd(KIND_START, SHAPE_OUTLINE, -5, 7, 1, 1, 24'hC0FFEE);
    add_ticks(4);
    add_cmd(KIND_START, SHAPE_FILLED, -2048, 2047, 2, 1, 24'h0F0F0F);
    add_ticks(2);
    // Empty rectangles and the unused shape code leave the engine idle
    add_cmd(KIND_START, SHAPE_OUTLINE, 10, 10, 0, 5, 24'h808080);
    add_cmd(KIND_START, SHAPE_UNUSED, 1, 2, 3, 4, 24'h7F7F7F);
    add_cmd(KIND_START, SHAPE_FILLED, 0, 0, 3, -2048, 24'hF0F0F0);
    add_ticks(1);

    // Random sequences, mostly complete commands with short lengths
    while (cmd_pending.size() < TOTAL_ITEMS) begin
      gen_phase = (cmd_pending.size() < 320) ? 0 : (cmd_pending.size() < 600) ? 1 : 2;
      if (!pressure_done && gen_phase == 2) begin
        // Drain first, then stall the pixel side under a stream of ticks
        add_cmd(KIND_START, SHAPE_LINE, -1000, 5, -700, 60, 24'($urandom), 1'b1, 1'b1);
        add_ticks(150);
        pressure_done = 1'b1;
      end
      roll = $urandom_range(99);
      if (roll < 85) begin
        pick = $urandom_range(3);
        ax   = $urandom_range(4095) - 2048;
        ay   = $urandom_range(4095) - 2048;
        if (pick < 2) begin
          shp = SHAPE_LINE;
          dx  = $urandom_range(18) - 9;
          dy  = $urandom_range(18) - 9;
          bx  = (ax + dx > 2047 || ax + dx < -2048) ? ax - dx : ax + dx;
          by  = (ay + dy > 2047 || ay + dy < -2048) ? ay - dy : ay + dy;
          dx  = (dx < 0) ? -dx : dx;
          dy  = (dy < 0) ? -dy : dy;
          count = ((dx > dy) ? dx : dy) + 1;
        end else begin
          shp   = (pick == 2) ? SHAPE_OUTLINE : SHAPE_FILLED;
          bx    = $urandom_range(1, 6);
          by    = $urandom_range(1, 5);
          count = (pick == 2) ? 2 * bx + 2 * by : bx * by;
        end
        // Usually run the command to its end, sometimes cut it short
        if ($urandom_range(9) < 7) n = count + $urandom_range(2);
        else n = $urandom_range(count - 1);
        add_cmd(KIND_START, shp, ax, ay, bx, by, 24'($urandom));
        add_ticks(n);
      end else if (roll < 93) begin
        add_cmd(KIND_START, 2'($urandom), $urandom, $urandom, $urandom, $urandom,
                24'($urandom));
        add_ticks($urandom_range(4));
      end else begin
        add_ticks($urandom_range(1, 3));
      end
    end

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (cmd_pending.size() != 0 || cmd_bus.valid) @(posedge clk_i);
    while (pixel_expect.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (fail_count == 0 && pixel_expect.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule : bresenham_line_rect_drawer_top_tb
